@@ rtl/mcbd_pkg.sv @@
// Shared types and constants for the main CPU bus decoder.
// Holds the memory map, register indexes, request and result records, and
// the controller-to-datapath command record. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mcbd_pkg;

    // Store depths.
    localparam int WORK_RAM_DEPTH_DEF   = 4096;
    localparam int FG_RAM_DEPTH_DEF     = 2048;
    localparam int BG_RAM_DEPTH_DEF     = 1024;
    localparam int SPRITE_RAM_DEPTH_DEF = 128;

    // Configuration port.
    localparam int   CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIP_A = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIP_B = 1'b1;
    localparam logic [7:0] DIP_A_RESET = 8'h37;
    localparam logic [7:0] DIP_B_RESET = 8'hDF;

    // Access kinds.
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Memory map.
    localparam logic [15:0] ADDR_BANK_WIN   = 16'h8000;
    localparam logic [15:0] ADDR_IO_BASE    = 16'hC000;
    localparam logic [15:0] ADDR_SYS_PORT   = 16'hC000;
    localparam logic [15:0] ADDR_P1_PORT    = 16'hC001;
    localparam logic [15:0] ADDR_P2_PORT    = 16'hC002;
    localparam logic [15:0] ADDR_DIP_A      = 16'hC003;
    localparam logic [15:0] ADDR_DIP_B      = 16'hC004;
    localparam logic [15:0] ADDR_SND_LATCH  = 16'hC800;
    localparam logic [15:0] ADDR_SCROLL_LO  = 16'hC802;
    localparam logic [15:0] ADDR_SCROLL_HI  = 16'hC803;
    localparam logic [15:0] ADDR_SND_RESET  = 16'hC804;
    localparam logic [15:0] ADDR_PALETTE    = 16'hC805;
    localparam logic [15:0] ADDR_BANK_SEL   = 16'hC806;
    localparam logic [15:0] ADDR_SPRITE_LO  = 16'hCC00;
    localparam logic [15:0] ADDR_SPRITE_END = 16'hCC80;
    localparam logic [15:0] ADDR_FG_END     = 16'hD800;
    localparam logic [15:0] ADDR_BG_END     = 16'hDC00;
    localparam logic [3:0]  PAGE_VIDEO      = 4'hD;
    localparam logic [3:0]  PAGE_WORK       = 4'hE;
    localparam int          SND_RESET_BIT   = 4;

    // Source of the read byte.
    localparam logic [2:0] RSEL_ZERO = 3'd0;
    localparam logic [2:0] RSEL_SYS  = 3'd1;
    localparam logic [2:0] RSEL_P1   = 3'd2;
    localparam logic [2:0] RSEL_P2   = 3'd3;
    localparam logic [2:0] RSEL_DIPA = 3'd4;
    localparam logic [2:0] RSEL_DIPB = 3'd5;
    localparam logic [2:0] RSEL_FG   = 3'd6;
    localparam logic [2:0] RSEL_WORK = 3'd7;
    localparam logic [2:0] RSEL_BG   = 3'd6;

    // One bus access.
    typedef struct packed {
        logic        func;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [7:0]  system_port;
        logic [7:0]  player1_port;
        logic [7:0]  player2_port;
    } t_req;

    // One result.
    typedef struct packed {
        logic [7:0]  read_data;
        logic        rom_read;
        logic [16:0] rom_address;
        logic        unmapped;
        logic        sound_cpu_reset;
        logic [7:0]  sound_latch_value;
        logic [15:0] scroll_value;
        logic [7:0]  palette_select;
        logic [7:0]  bank_select;
    } t_rsp;

    // Controller commands to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } t_dp_cmd;

endpackage

`default_nettype wire

@@ rtl/mcbd_if.sv @@
// Valid/ready channel interfaces for bus accesses and their results.
// Depends on nothing; field widths follow the bus decoder's item layout.
`timescale 1ns / 1ps
`default_nettype none

interface mcbd_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  system_port;
    logic [7:0]  player1_port;
    logic [7:0]  player2_port;

    modport source (output valid, func, address, write_data, system_port,
                    player1_port, player2_port, input ready);
    modport sink   (input valid, func, address, write_data, system_port,
                    player1_port, player2_port, output ready);
endinterface

interface mcbd_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic        rom_read;
    logic [16:0] rom_address;
    logic        unmapped;
    logic        sound_cpu_reset;
    logic [7:0]  sound_latch_value;
    logic [15:0] scroll_value;
    logic [7:0]  palette_select;
    logic [7:0]  bank_select;

    modport source (output valid, read_data, rom_read, rom_address, unmapped,
                    sound_cpu_reset, sound_latch_value, scroll_value,
                    palette_select, bank_select, input ready);
    modport sink   (input valid, read_data, rom_read, rom_address, unmapped,
                    sound_cpu_reset, sound_latch_value, scroll_value,
                    palette_select, bank_select, output ready);
endinterface

`default_nettype wire

@@ rtl/mcbd_ctrl.sv @@
// Sequencing controller for the bus decoder: accept, execute, load, deliver.
// Depends on mcbd_pkg for the datapath command record.
`timescale 1ns / 1ps
`default_nettype none

module mcbd_ctrl
    import mcbd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output t_dp_cmd      o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: n_state = S_LOAD;
            S_LOAD: n_state = S_OUT;
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Handshake and datapath commands.
    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = (r_state == S_OUT);
    assign o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec    = (r_state == S_EXEC);
    assign o_cmd.load    = (r_state == S_LOAD);

endmodule

`default_nettype wire

@@ rtl/mcbd_dp.sv @@
// Datapath of the bus decoder: address decode, RAMs, latch registers and the
// result register. Depends on mcbd_pkg; driven by mcbd_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module mcbd_dp
    import mcbd_pkg::*;
#(
    parameter int WORK_RAM_DEPTH   = WORK_RAM_DEPTH_DEF,
    parameter int FG_RAM_DEPTH     = FG_RAM_DEPTH_DEF,
    parameter int BG_RAM_DEPTH     = BG_RAM_DEPTH_DEF,
    parameter int SPRITE_RAM_DEPTH = SPRITE_RAM_DEPTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [7:0]           i_cfg_data,
    input  wire t_dp_cmd              i_cmd,
    input  wire t_req                 i_req,
    output t_rsp                      o_rsp
);

    localparam int WORK_AW   = $clog2(WORK_RAM_DEPTH);
    localparam int FG_AW     = $clog2(FG_RAM_DEPTH);
    localparam int BG_AW     = $clog2(BG_RAM_DEPTH);
    localparam int SPRITE_AW = $clog2(SPRITE_RAM_DEPTH);

    // Configuration and latch registers.
    logic [7:0]  r_dip_a;
    logic [7:0]  r_dip_b;
    logic [7:0]  r_snd_latch;
    logic [15:0] r_scroll;
    logic [7:0]  r_palette;
    logic [7:0]  r_bank;

    // Captured item.
    t_req r_req;

    // Decode results held from the execute cycle to the load cycle.
    logic [2:0]  r_rsel;
    logic        r_rom_rd;
    logic [16:0] r_rom_addr;
    logic        r_unm;
    logic        r_snd_rst;

    // Memories and their registered read data.
    logic [7:0] r_work_ram   [WORK_RAM_DEPTH];
    logic [7:0] r_fg_ram     [FG_RAM_DEPTH];
    logic [7:0] r_bg_ram     [BG_RAM_DEPTH];
    logic [7:0] r_sprite_ram [SPRITE_RAM_DEPTH];
    logic [7:0] r_work_q;
    logic [7:0] r_fg_q;
    logic [7:0] r_bg_q;

    t_rsp r_rsp;

    // Decode signals.
    logic        is_wr;
    logic [3:0]  page;
    logic        hit_fg;
    logic        hit_bg;
    logic        hit_work;
    logic        hit_sprite;
    logic        we_work;
    logic        we_fg;
    logic        we_bg;
    logic        we_sprite;
    logic        we_snd;
    logic        we_scr_lo;
    logic        we_scr_hi;
    logic        we_pal;
    logic        we_bank;
    logic [2:0]  n_rsel;
    logic        n_rom_rd;
    logic [16:0] n_rom_addr;
    logic        n_unm;
    logic        n_snd_rst;
    logic [7:0]  rd_byte;

    // Capture the accepted item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
    end

    // Region hits; the video and work hits serve reads and writes, the sprite hit writes only.
    assign is_wr      = (r_req.func == FUNC_WRITE);
    assign page       = r_req.address[15:12];
    assign hit_fg     = (page == PAGE_VIDEO) && (r_req.address < ADDR_FG_END);
    assign hit_bg     = (page == PAGE_VIDEO) && !hit_fg && (r_req.address < ADDR_BG_END);
    assign hit_work   = (page == PAGE_WORK);
    assign hit_sprite = (r_req.address >= ADDR_SPRITE_LO) &&
                        (r_req.address < ADDR_SPRITE_END);

    // Address decode for the execute cycle.
    always_comb begin
        n_rsel     = RSEL_ZERO;
        n_rom_rd   = 1'b0;
        n_rom_addr = '0;
        n_unm      = 1'b0;
        n_snd_rst  = 1'b0;
        we_work    = 1'b0;
        we_fg      = 1'b0;
        we_bg      = 1'b0;
        we_sprite  = 1'b0;
        we_snd     = 1'b0;
        we_scr_lo  = 1'b0;
        we_scr_hi  = 1'b0;
        we_pal     = 1'b0;
        we_bank    = 1'b0;
        if (!is_wr) begin
            if (r_req.address < ADDR_BANK_WIN) begin
                n_rom_rd   = 1'b1;
                n_rom_addr = {1'b0, r_req.address};
            end else if (r_req.address < ADDR_IO_BASE) begin
                // Banked window: 64K base plus a 16K page picked by the bank.
                n_rom_rd   = 1'b1;
                n_rom_addr = {1'b1, r_bank[1:0], r_req.address[13:0]};
            end else if (r_req.address == ADDR_SYS_PORT) begin
                n_rsel = RSEL_SYS;
            end else if (r_req.address == ADDR_P1_PORT) begin
                n_rsel = RSEL_P1;
            end else if (r_req.address == ADDR_P2_PORT) begin
                n_rsel = RSEL_P2;
            end else if (r_req.address == ADDR_DIP_A) begin
                n_rsel = RSEL_DIPA;
            end else if (r_req.address == ADDR_DIP_B) begin
                n_rsel = RSEL_DIPB;
            end else if (hit_fg || hit_bg) begin
                n_rsel = RSEL_FG;
            end else if (hit_work) begin
                n_rsel = RSEL_WORK;
            end else begin
                n_unm = 1'b1;
            end
        end else begin
            if (hit_sprite) begin
                we_sprite = 1'b1;
            end else if (r_req.address == ADDR_SND_LATCH) begin
                we_snd = 1'b1;
            end else if (r_req.address == ADDR_SCROLL_LO) begin
                we_scr_lo = 1'b1;
            end else if (r_req.address == ADDR_SCROLL_HI) begin
                we_scr_hi = 1'b1;
            end else if (r_req.address == ADDR_SND_RESET) begin
                n_snd_rst = r_req.write_data[SND_RESET_BIT];
            end else if (r_req.address == ADDR_PALETTE) begin
                we_pal = 1'b1;
            end else if (r_req.address == ADDR_BANK_SEL) begin
                we_bank = 1'b1;
            end else if (hit_fg) begin
                we_fg = 1'b1;
            end else if (hit_bg) begin
                we_bg = 1'b1;
            end else if (hit_work) begin
                we_work = 1'b1;
            end else begin
                n_unm = 1'b1;
            end
        end
    end

    // Hold the decode for the load cycle; a background read reuses the video
    // select and is told apart by the address below.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_rsel     <= n_rsel;
            r_rom_rd   <= n_rom_rd;
            r_rom_addr <= n_rom_addr;
            r_unm      <= n_unm;
            r_snd_rst  <= n_snd_rst;
        end
    end

    // Work RAM.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (we_work) begin
                r_work_ram[r_req.address[WORK_AW-1:0]] <= r_req.write_data;
            end
            r_work_q <= r_work_ram[r_req.address[WORK_AW-1:0]];
        end
    end

    // Foreground RAM.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (we_fg) begin
                r_fg_ram[r_req.address[FG_AW-1:0]] <= r_req.write_data;
            end
            r_fg_q <= r_fg_ram[r_req.address[FG_AW-1:0]];
        end
    end

    // Background RAM.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (we_bg) begin
                r_bg_ram[r_req.address[BG_AW-1:0]] <= r_req.write_data;
            end
            r_bg_q <= r_bg_ram[r_req.address[BG_AW-1:0]];
        end
    end

    // Sprite RAM is written by the CPU only; nothing in this block reads it.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && we_sprite) begin
            r_sprite_ram[r_req.address[SPRITE_AW-1:0]] <= r_req.write_data;
        end
    end

    // Dip switches and latch registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dip_a     <= DIP_A_RESET;
            r_dip_b     <= DIP_B_RESET;
            r_snd_latch <= '0;
            r_scroll    <= '0;
            r_palette   <= '0;
            r_bank      <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == CFG_DIP_A)) begin
                r_dip_a <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_idx == CFG_DIP_B)) begin
                r_dip_b <= i_cfg_data;
            end
            if (i_cmd.exec) begin
                if (we_snd) begin
                    r_snd_latch <= r_req.write_data;
                end
                if (we_scr_lo) begin
                    r_scroll[7:0] <= r_req.write_data;
                end
                if (we_scr_hi) begin
                    r_scroll[15:8] <= r_req.write_data;
                end
                if (we_pal) begin
                    r_palette <= r_req.write_data;
                end
                if (we_bank) begin
                    r_bank <= r_req.write_data;
                end
            end
        end
    end

    // Read byte selection.
    always_comb begin
        case (r_rsel)
            RSEL_ZERO: rd_byte = '0;
            RSEL_SYS:  rd_byte = r_req.system_port;
            RSEL_P1:   rd_byte = r_req.player1_port;
            RSEL_P2:   rd_byte = r_req.player2_port;
            RSEL_DIPA: rd_byte = r_dip_a;
            RSEL_DIPB: rd_byte = r_dip_b;
            RSEL_FG:   rd_byte = (r_req.address < ADDR_FG_END) ? r_fg_q : r_bg_q;
            RSEL_WORK: rd_byte = r_work_q;
            default:   rd_byte = '0;
        endcase
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rsp.read_data         <= rd_byte;
            r_rsp.rom_read          <= r_rom_rd;
            r_rsp.rom_address       <= r_rom_addr;
            r_rsp.unmapped          <= r_unm;
            r_rsp.sound_cpu_reset   <= r_snd_rst;
            r_rsp.sound_latch_value <= r_snd_latch;
            r_rsp.scroll_value      <= r_scroll;
            r_rsp.palette_select    <= r_palette;
            r_rsp.bank_select       <= r_bank;
        end
    end

    assign o_rsp = r_rsp;

endmodule

`default_nettype wire

@@ rtl/main_cpu_bus_decoder_top.sv @@
// Main CPU bus decoder: one bus access in, one result out.
// The request arrives on a valid/ready sink channel and the result leaves on a
// valid/ready source channel; both follow mcbd_if. The dip switch bytes are
// written through a plain write port (index 0: switch A at C003, index 1:
// switch B at C004); the user must write them only while the block is idle,
// which the block itself does not enforce. Each access passes through the
// accept, an execute state in which the internal RAMs are read or written and
// the latches updated, a load state that fills the result register from the
// registered RAM data, and an output state that offers the result until it is
// accepted. The next access is taken in the cycle after the result is
// accepted, so no new access is taken while one is still in flight.
// While the receiver holds ready low the result stays put and no new access
// is accepted. Synchronous reset returns the controller to idle, clears the
// sound latch, scroll, palette and bank registers, and restores the dip
// switches to 0x37 and 0xDF; RAM contents are undefined until written.
// Depends on mcbd_pkg, mcbd_if, mcbd_ctrl and mcbd_dp.
`timescale 1ns / 1ps
`default_nettype none

module main_cpu_bus_decoder_top
    import mcbd_pkg::*;
#(
    parameter int WORK_RAM_DEPTH   = WORK_RAM_DEPTH_DEF,
    parameter int FG_RAM_DEPTH     = FG_RAM_DEPTH_DEF,
    parameter int BG_RAM_DEPTH     = BG_RAM_DEPTH_DEF,
    parameter int SPRITE_RAM_DEPTH = SPRITE_RAM_DEPTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [7:0]           i_cfg_data,
    mcbd_req_if.sink                  i_req,
    mcbd_rsp_if.source                o_rsp
);

    t_dp_cmd cmd;
    t_req    req;
    t_rsp    rsp;

    // Pack the request fields for the datapath.
    assign req.func         = i_req.func;
    assign req.address      = i_req.address;
    assign req.write_data   = i_req.write_data;
    assign req.system_port  = i_req.system_port;
    assign req.player1_port = i_req.player1_port;
    assign req.player2_port = i_req.player2_port;

    mcbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    mcbd_dp #(
        .WORK_RAM_DEPTH   (WORK_RAM_DEPTH),
        .FG_RAM_DEPTH     (FG_RAM_DEPTH),
        .BG_RAM_DEPTH     (BG_RAM_DEPTH),
        .SPRITE_RAM_DEPTH (SPRITE_RAM_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .i_req      (req),
        .o_rsp      (rsp)
    );

    // Unpack the result onto the output channel.
    assign o_rsp.read_data         = rsp.read_data;
    assign o_rsp.rom_read          = rsp.rom_read;
    assign o_rsp.rom_address       = rsp.rom_address;
    assign o_rsp.unmapped          = rsp.unmapped;
    assign o_rsp.sound_cpu_reset   = rsp.sound_cpu_reset;
    assign o_rsp.sound_latch_value = rsp.sound_latch_value;
    assign o_rsp.scroll_value      = rsp.scroll_value;
    assign o_rsp.palette_select    = rsp.palette_select;
    assign o_rsp.bank_select       = rsp.bank_select;

endmodule

`default_nettype wire

@@ tb/main_cpu_bus_decoder_top_tb.sv @@
// Self-checking testbench for main_cpu_bus_decoder_top: directed and random bus
// accesses, a built-in decoder predictor and an in-order result scoreboard.
// Depends on mcbd_pkg, mcbd_if and the bus decoder RTL.
`timescale 1ns / 1ps

module main_cpu_bus_decoder_top_tb;
    import mcbd_pkg::*;

    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          RESET_CYCLES   = 12;
    localparam int          PHASE_ITEMS    = 320;
    localparam int          NUM_PHASES     = 6;
    localparam int          STEADY_PHASE   = 1;
    localparam int          PRESSURE_PHASE = 3;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          DIR_ROWS       = 28;
    localparam logic [16:0] BANK_ROM_BASE  = 17'h10000;
    localparam logic [16:0] BANK_SIZE      = 17'h4000;
    localparam logic [15:0] FG_BASE        = {PAGE_VIDEO, 12'h000};
    localparam logic [15:0] WORK_BASE      = {PAGE_WORK, 12'h000};

    // One directed access; the decode fields are typed in only on pinned rows.
    typedef struct packed {
        logic        func;
        logic [15:0] address;
        logic [7:0]  data;
        logic [7:0]  sys;
        logic [7:0]  p1;
        logic [7:0]  p2;
        logic        pinned;
        logic [7:0]  rd;
        logic        rom;
        logic [16:0] rom_addr;
        logic        unm;
        logic        snd;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [7:0] i_cfg_data;

    mcbd_req_if req_if ();
    mcbd_rsp_if rsp_if ();

    main_cpu_bus_decoder_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the decoder state.
    logic [7:0]  work_mem   [WORK_RAM_DEPTH_DEF];
    logic [7:0]  fg_mem     [FG_RAM_DEPTH_DEF];
    logic [7:0]  bg_mem     [BG_RAM_DEPTH_DEF];
    logic [7:0]  sprite_mem [SPRITE_RAM_DEPTH_DEF];
    logic [7:0]  latch_q    = 8'h00;
    logic [15:0] scroll_q   = 16'h0000;
    logic [7:0]  palette_q  = 8'h00;
    logic [7:0]  bank_q     = 8'h00;
    logic [7:0]  dip_a_q    = DIP_A_RESET;
    logic [7:0]  dip_b_q    = DIP_B_RESET;

    // Addresses already written, so that random reads only hit defined RAM.
    bit          work_written [WORK_RAM_DEPTH_DEF];
    bit          fg_written   [FG_RAM_DEPTH_DEF];
    bit          bg_written   [BG_RAM_DEPTH_DEF];
    logic [15:0] work_list [$];
    logic [15:0] fg_list   [$];
    logic [15:0] bg_list   [$];

    t_rsp     pending_results [$];
    t_dir_row dir_table [DIR_ROWS];
    int       mismatch_count  = 0;
    int       results_checked = 0;
    int       quiet_cycles    = 0;
    bit       hold_off_req    = 1'b0;
    bit       steady_flow     = 1'b0;

    // Decode one access against the shadow state and return its result.
    function automatic t_rsp decode_access(t_req r);
        t_rsp       o;
        logic [3:0] page;
        o    = '0;
        page = r.address[15:12];
        if (r.func == FUNC_READ) begin
            if (r.address < ADDR_BANK_WIN) begin
                o.rom_read    = 1'b1;
                o.rom_address = {1'b0, r.address};
            end else if (r.address < ADDR_IO_BASE) begin
                o.rom_read    = 1'b1;
                o.rom_address = BANK_ROM_BASE + 17'(bank_q[1:0]) * BANK_SIZE
                                + 17'(r.address[13:0]);
            end else if (r.address == ADDR_SYS_PORT) begin
                o.read_data = r.system_port;
            end else if (r.address == ADDR_P1_PORT) begin
                o.read_data = r.player1_port;
            end else if (r.address == ADDR_P2_PORT) begin
                o.read_data = r.player2_port;
            end else if (r.address == ADDR_DIP_A) begin
                o.read_data = dip_a_q;
            end else if (r.address == ADDR_DIP_B) begin
                o.read_data = dip_b_q;
            end else if (page == PAGE_VIDEO && r.address < ADDR_FG_END) begin
                o.read_data = fg_mem[r.address[10:0]];
            end else if (page == PAGE_VIDEO && r.address < ADDR_BG_END) begin
                o.read_data = bg_mem[r.address[9:0]];
            end else if (page == PAGE_WORK) begin
                o.read_data = work_mem[r.address[11:0]];
            end else begin
                o.unmapped = 1'b1;
            end
        end else begin
            if (r.address >= ADDR_SPRITE_LO && r.address < ADDR_SPRITE_END) begin
                sprite_mem[r.address[6:0]] = r.write_data;
            end else if (r.address == ADDR_SND_LATCH) begin
                latch_q = r.write_data;
            end else if (r.address == ADDR_SCROLL_LO) begin
                scroll_q[7:0] = r.write_data;
            end else if (r.address == ADDR_SCROLL_HI) begin
                scroll_q[15:8] = r.write_data;
            end else if (r.address == ADDR_SND_RESET) begin
                o.sound_cpu_reset = r.write_data[SND_RESET_BIT];
            end else if (r.address == ADDR_PALETTE) begin
                palette_q = r.write_data;
            end else if (r.address == ADDR_BANK_SEL) begin
                bank_q = r.write_data;
            end else if (page == PAGE_VIDEO && r.address < ADDR_FG_END) begin
                fg_mem[r.address[10:0]] = r.write_data;
                if (!fg_written[r.address[10:0]]) begin
                    fg_written[r.address[10:0]] = 1'b1;
                    fg_list.push_back(r.address);
                end
            end else if (page == PAGE_VIDEO && r.address < ADDR_BG_END) begin
                bg_mem[r.address[9:0]] = r.write_data;
                if (!bg_written[r.address[9:0]]) begin
                    bg_written[r.address[9:0]] = 1'b1;
                    bg_list.push_back(r.address);
                end
            end else if (page == PAGE_WORK) begin
                work_mem[r.address[11:0]] = r.write_data;
                if (!work_written[r.address[11:0]]) begin
                    work_written[r.address[11:0]] = 1'b1;
                    work_list.push_back(r.address);
                end
            end else begin
                o.unmapped = 1'b1;
            end
        end
        o.sound_latch_value = latch_q;
        o.scroll_value      = scroll_q;
        o.palette_select    = palette_q;
        o.bank_select       = bank_q;
        return o;
    endfunction

    // True for a read of a RAM entry that has never been written.
    function automatic bit reads_unwritten(t_req r);
        logic [3:0] page;
        page = r.address[15:12];
        if (r.func != FUNC_READ)
            return 1'b0;
        if (page == PAGE_VIDEO && r.address < ADDR_FG_END)
            return !fg_written[r.address[10:0]];
        if (page == PAGE_VIDEO && r.address < ADDR_BG_END)
            return !bg_written[r.address[9:0]];
        if (page == PAGE_WORK)
            return !work_written[r.address[11:0]];
        return 1'b0;
    endfunction

    // Idle length: mostly none or short, now and then a long one.
    function automatic int rand_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Random access, weighted toward sequences that exercise the stores.
    function automatic t_req make_random_access();
        t_req r;
        int   pick;
        int   region;
        r.func         = FUNC_READ;
        r.address      = 16'($urandom);
        r.write_data   = 8'($urandom);
        r.system_port  = 8'($urandom);
        r.player1_port = 8'($urandom);
        r.player2_port = 8'($urandom);
        pick           = $urandom_range(0, 99);
        if (pick < 15) begin
            r.address = 16'($urandom_range(0, 16'hBFFF));
        end else if (pick < 22) begin
            r.func    = FUNC_WRITE;
            r.address = ADDR_BANK_SEL;
        end else if (pick < 32) begin
            r.func    = ($urandom_range(0, 9) == 0) ? FUNC_WRITE : FUNC_READ;
            r.address = ADDR_SYS_PORT + 16'($urandom_range(0, 4));
        end else if (pick < 47) begin
            r.func = FUNC_WRITE;
            region = $urandom_range(0, 2);
            case (region)
                0: r.address = FG_BASE + 16'($urandom_range(0, FG_RAM_DEPTH_DEF - 1));
                1: r.address = ADDR_FG_END + 16'($urandom_range(0, BG_RAM_DEPTH_DEF - 1));
                default: r.address = WORK_BASE
                                     + 16'($urandom_range(0, WORK_RAM_DEPTH_DEF - 1));
            endcase
        end else if (pick < 67) begin
            // Read back an entry that holds a known byte.
            region = $urandom_range(0, 2);
            if (region == 0 && fg_list.size() > 0)
                r.address = fg_list[$urandom_range(0, fg_list.size() - 1)];
            else if (region == 1 && bg_list.size() > 0)
                r.address = bg_list[$urandom_range(0, bg_list.size() - 1)];
            else if (work_list.size() > 0)
                r.address = work_list[$urandom_range(0, work_list.size() - 1)];
            else begin
                r.func    = FUNC_WRITE;
                r.address = WORK_BASE;
            end
        end else if (pick < 80) begin
            r.func    = ($urandom_range(0, 3) == 0) ? FUNC_READ : FUNC_WRITE;
            r.address = ADDR_SND_LATCH + 16'($urandom_range(0, 6));
        end else if (pick < 85) begin
            r.func    = ($urandom_range(0, 3) == 0) ? FUNC_READ : FUNC_WRITE;
            r.address = ADDR_SPRITE_LO + 16'($urandom_range(0, SPRITE_RAM_DEPTH_DEF - 1));
        end else begin
            // Noise over the whole map; undefined RAM reads become writes.
            r.func = 1'($urandom);
            if (reads_unwritten(r))
                r.func = FUNC_WRITE;
        end
        return r;
    endfunction

    // Print one mismatch line and count it.
    task automatic flag_mismatch(string msg);
        $display("[%0t] result %0d: %s", $time, results_checked, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(string name, int got, int want);
        if (got != want)
            flag_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    task automatic check_result(t_rsp got, t_rsp want);
        compare_field("read_data", got.read_data, want.read_data);
        compare_field("rom_read", got.rom_read, want.rom_read);
        compare_field("rom_address", got.rom_address, want.rom_address);
        compare_field("unmapped", got.unmapped, want.unmapped);
        compare_field("sound_cpu_reset", got.sound_cpu_reset, want.sound_cpu_reset);
        compare_field("sound_latch_value", got.sound_latch_value, want.sound_latch_value);
        compare_field("scroll_value", got.scroll_value, want.scroll_value);
        compare_field("palette_select", got.palette_select, want.palette_select);
        compare_field("bank_select", got.bank_select, want.bank_select);
    endtask

    // Offer one item, after a random gap unless the flow is steady, and record its expected result once taken.
    task automatic send_access(t_req r, bit pinned, t_rsp pin);
        int   gap;
        t_rsp want;
        gap = steady_flow ? 0 : rand_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.func         <= r.func;
        req_if.address      <= r.address;
        req_if.write_data   <= r.write_data;
        req_if.system_port  <= r.system_port;
        req_if.player1_port <= r.player1_port;
        req_if.player2_port <= r.player2_port;
        do @(posedge i_clk); while (!req_if.ready);
        want = decode_access(r);
        if (pinned) begin
            want.read_data       = pin.read_data;
            want.rom_read        = pin.rom_read;
            want.rom_address     = pin.rom_address;
            want.unmapped        = pin.unmapped;
            want.sound_cpu_reset = pin.sound_cpu_reset;
        end
        pending_results.push_back(want);
    endtask

    // Write both dip switch bytes once every result is back.
    task automatic load_dip_switches(logic [7:0] a, logic [7:0] b);
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_DIP_A;
        i_cfg_data <= a;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_DIP_B;
        i_cfg_data <= b;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        dip_a_q = a;
        dip_b_q = b;
    endtask

    // Result side: check each accepted item, then pick next cycle's ready.
    initial begin : result_sink
        int   stall_left;
        int   g;
        t_rsp seen;
        stall_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_if.valid && rsp_if.ready) begin
                seen = {rsp_if.read_data, rsp_if.rom_read, rsp_if.rom_address,
                        rsp_if.unmapped, rsp_if.sound_cpu_reset, rsp_if.sound_latch_value,
                        rsp_if.scroll_value, rsp_if.palette_select, rsp_if.bank_select};
                if (pending_results.size() == 0)
                    flag_mismatch("result arrived with nothing pending");
                else
                    check_result(seen, pending_results.pop_front());
                results_checked++;
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_CYCLES - 1;
                rsp_if.ready <= 1'b0;
            end else if (steady_flow) begin
                rsp_if.ready <= 1'b1;
            end else begin
                g = rand_gap();
                if (g > 0) begin
                    stall_left = g - 1;
                    rsp_if.ready <= 1'b0;
                end else begin
                    rsp_if.ready <= 1'b1;
                end
            end
        end
    end

    // Watchdog: too long without any item moving ends the run.
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stimulus: reset, directed table, then random phases under several dip settings.
    initial begin : stimulus
        t_req     r;
        t_rsp     pin;
        t_dir_row row;
        logic [7:0] dip_a;
        logic [7:0] dip_b;

        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_idx           <= CFG_DIP_A;
        i_cfg_data          <= 8'h00;
        req_if.valid        <= 1'b0;
        req_if.func         <= FUNC_READ;
        req_if.address      <= 16'h0000;
        req_if.write_data   <= 8'h00;
        req_if.system_port  <= 8'h00;
        req_if.player1_port <= 8'h00;
        req_if.player2_port <= 8'h00;

        dir_table = '{
            // Dip switches after reset.
            '{FUNC_READ,  ADDR_DIP_A,     8'h00, 8'h00, 8'h00, 8'h00,
              1'b1, DIP_A_RESET, 1'b0, 17'h00000, 1'b0, 1'b0},
            '{FUNC_READ,  ADDR_DIP_B,     8'h00, 8'h00, 8'h00, 8'h00,
              1'b1, DIP_B_RESET, 1'b0, 17'h00000, 1'b0, 1'b0},
            // Fixed ROM and bank 0 window edges.
            '{FUNC_READ,  16'h0000,       8'hFF, 8'h00, 8'h00, 8'h00,
              1'b1, 8'h00, 1'b1, 17'h00000, 1'b0, 1'b0},
            '{FUNC_READ,  16'h7FFF,       8'h00, 8'h00, 8'h00, 8'h00,
              1'b1, 8'h00, 1'b1, 17'h07FFF, 1'b0, 1'b0},
            '{FUNC_READ,  ADDR_BANK_WIN,  8'h00, 8'h00, 8'h00, 8'h00,
              1'b1, 8'h00, 1'b1, 17'h10000, 1'b0, 1'b0},
            '{FUNC_READ,  16'hBFFF,       8'h00, 8'h00, 8'h00, 8'h00,
              1'b1, 8'h00, 1'b1, 17'h13FFF, 1'b0, 1'b0},
            // Each port returns its own byte.
            '{FUNC_READ,  ADDR_SYS_PORT,  8'h00, 8'h00, 8'hFF, 8'hFF,
              1'b1, 8'h00, 1'b0, 17'h00000, 1'b0, 1'b0},
            '{FUNC_READ,  ADDR_P1_PORT,   8'h00, 8'h00, 8'hFF, 8'h00,
              1'b1, 8'hFF, 1'b0, 17'h00000, 1'b0, 1'b0},
            '{FUNC_READ,  ADDR_P2_PORT,   8'h00, 8'hFF, 8'h00, 8'hA5,
              1'b1, 8'hA5, 1'b0, 17'h00000, 1'b0, 1'b0},
            // Bank byte 0xFF wraps to window 3.
            '{FUNC_WRITE, ADDR_BANK_SEL,  8'hFF, 8'h00, 8'h00, 8'h00,
              1'b0, 8'h00, 1'b0, 17'h00000, 1'b0, 1'b0},
            '{FUNC_READ,  ADDR_BANK_WIN,  8'h00, 8'h00, 8'h00, 8'h00,
              1'b1, 8'h00, 1'b1, 17'h1C000, 1'b0, 1'b0},
            '{FUNC_READ,  16'hBFFF,       8'h00, 8'h00, 8'h00, 8'h00,
              1'b1, 8'h00, 1'b1, 17'h1FFFF, 1'b0, 1'b0},
            // Latch registers.
            '{FUNC_WRITE, ADDR_SND_LATCH, 8'hFF, 8'h00, 8'h00, 8'h00,
              1'b0, 8'h00, 1'b0, 17'h00000, 1'b0, 1'b0},
            '{FUNC_WRITE, ADDR_SCROLL_LO, 8'h00, 8'h00, 8'h00, 8'h00,
              1'b0, 8'h00, 1'b0, 17'h00000, 1'b0, 1'b0},
            '{FUNC_WRITE, ADDR_SCROLL_HI, 8'hFF, 8'h00, 8'h00, 8'h00,
              1'b0, 8'h00, 1'b0, 17'h00000, 1'b0, 1'b0},
            '{FUNC_WRITE, ADDR_SND_RESET, 8'h10, 8'h00, 8'h00, 8'h00,
              1'b1, 8'h00, 1'b0, 17'h00000, 1'b0, 1'b1},
            '{FUNC_WRITE, ADDR_PALETTE,   8'h80, 8'h00, 8'h00, 8'h00,
              1'b0, 8'h00, 1'b0, 17'h00000, 1'b0, 1'b0},
            // RAM write then read back at region edges, and a sprite RAM write.
            '{FUNC_WRITE, 16'hD000,       8'h5A, 8'h00, 8'h00, 8'h00,
              1'b0, 8'h00, 1'b0, 17'h00000, 1'b0, 1'b0},
            '{FUNC_READ,  16'hD000,       8'h00, 8'h00, 8'h00, 8'h00,
              1'b0, 8'h00, 1'b0, 17'h00000, 1'b0, 1'b0},
            '{FUNC_WRITE, 16'hDBFF,       8'hC3, 8'h00, 8'h00, 8'h00,
              1'b0, 8'h00, 1'b0, 17'h00000, 1'b0, 1'b0},
            '{FUNC_READ,  16'hDBFF,       8'h00, 8'h00, 8'h00, 8'h00,
              1'b0, 8'h00, 1'b0, 17'h00000, 1'b0, 1'b0},
            '{FUNC_WRITE, 16'hEFFF,       8'h96, 8'h00, 8'h00, 8'h00,
              1'b0, 8'h00, 1'b0, 17'h00000, 1'b0, 1'b0},
            '{FUNC_READ,  16'hEFFF,       8'h00, 8'h00, 8'h00, 8'h00,
              1'b0, 8'h00, 1'b0, 17'h00000, 1'b0, 1'b0},
            '{FUNC_WRITE, 16'hCC7F,       8'h7E, 8'h00, 8'h00, 8'h00,
              1'b0, 8'h00, 1'b0, 17'h00000, 1'b0, 1'b0},
            // Unmapped reads and writes, sprite RAM read included.
            '{FUNC_READ,  ADDR_SPRITE_LO, 8'h00, 8'h00, 8'h00, 8'h00,
              1'b1, 8'h00, 1'b0, 17'h00000, 1'b1, 1'b0},
            '{FUNC_READ,  16'hFFFF,       8'h00, 8'h00, 8'h00, 8'h00,
              1'b1, 8'h00, 1'b0, 17'h00000, 1'b1, 1'b0},
            '{FUNC_WRITE, 16'h0000,       8'hFF, 8'h00, 8'h00, 8'h00,
              1'b1, 8'h00, 1'b0, 17'h00000, 1'b1, 1'b0},
            '{FUNC_WRITE, 16'hC801,       8'hFF, 8'h00, 8'h00, 8'h00,
              1'b1, 8'h00, 1'b0, 17'h00000, 1'b1, 1'b0}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table.
        for (int i = 0; i < DIR_ROWS; i++) begin
            row                 = dir_table[i];
            r.func              = row.func;
            r.address           = row.address;
            r.write_data        = row.data;
            r.system_port       = row.sys;
            r.player1_port      = row.p1;
            r.player2_port      = row.p2;
            pin                 = '0;
            pin.read_data       = row.rd;
            pin.rom_read        = row.rom;
            pin.rom_address     = row.rom_addr;
            pin.unmapped        = row.unm;
            pin.sound_cpu_reset = row.snd;
            send_access(r, row.pinned, pin);
        end

        // Random phases, each under its own dip switch setting.
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin dip_a = 8'h00; dip_b = 8'hFF; end
                1: begin dip_a = 8'hFF; dip_b = 8'h00; end
                3: begin dip_a = 8'hAA; dip_b = 8'h55; end
                5: begin dip_a = 8'hFF; dip_b = 8'hFF; end
                default: begin dip_a = 8'($urandom); dip_b = 8'($urandom); end
            endcase
            load_dip_switches(dip_a, dip_b);
            steady_flow = (p == STEADY_PHASE);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == PRESSURE_PHASE && i == PHASE_ITEMS / 3)
                    hold_off_req = 1'b1;
                send_access(make_random_access(), 1'b0, '0);
            end
        end

        // Drain and report.
        req_if.valid <= 1'b0;
        steady_flow = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
